FILE: sv/quadratic_root_solver_unit_defines.svh
// ----------------------------------------------------------------------------
// quadratic root solver assertion macros
// shared property wrappers clocked on clock and disabled during reset
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH

// same-cycle implication
`define QRS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define QRS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// widths, codes and stage payload types of the quadratic root solver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qrs_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   // arithmetic widths
   localparam int PROD_W   = 2 * WORD_BITS;
   localparam int FAC_W    = PROD_W + 2;
   localparam int DIFF_W   = FAC_W + 1;
   localparam int DISC_W   = PROD_W + 1;
   localparam int RAD_W    = DISC_W + (DISC_W % 2);
   localparam int ROOT_W   = RAD_W / 2;
   localparam int SQ_REM_W = ROOT_W + 4;
   localparam int NUM_W    = ROOT_W + 1;
   localparam int NB_W     = NUM_W + 1;
   localparam int DVD_W    = NUM_W + FRAC_BITS;
   localparam int DEN_W    = WORD_BITS + 1;
   localparam int DV_REM_W = DEN_W + 1;

   // port widths
   localparam int REQ_W  = ((3 * WORD_BITS + 7) / 8) * 8;
   localparam int RSP_W  = ((2 * WORD_BITS + 1 + 7) / 8) * 8;
   localparam int KIND_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_DOUBLE  = 2'd0,
      KIND_TWO     = 2'd1,
      KIND_COMPLEX = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   // square root cell word
   typedef struct packed {
      logic [RAD_W-1:0]    rad;
      logic [ROOT_W-1:0]   root;
      logic [SQ_REM_W-1:0] rem;
   } sq_type;

   // divider cell word
   typedef struct packed {
      logic [DVD_W-1:0]    dvd;
      logic [DVD_W-1:0]    quo;
      logic [DV_REM_W-1:0] rem;
      logic [DEN_W-1:0]    den;
   } dv_type;

   // side data along the square root chain
   typedef struct packed {
      kind_type                kind;
      logic                    an;
      logic signed [NB_W-1:0]  nb;
      logic [DEN_W-1:0]        den;
   } side_type;

   // side data along the divider chain
   typedef struct packed {
      kind_type kind;
      logic     neg1;
      logic     neg2;
   } post_type;

endpackage

FILE: sv/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// one restoring square root step: two radicand bits in, one root bit out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qrs_sqrt_cell import qrs_pkg::*; (
   input  logic   clock,
   input  logic   load,
   input  sq_type sq_i,
   output sq_type sq_o
);

   sq_type              sq_ff;
   sq_type              sq_in;
   logic [SQ_REM_W-1:0] work;
   logic [SQ_REM_W-1:0] trial;

   // bring down two bits and try the next root bit
   always_comb begin
      work  = {sq_i.rem[SQ_REM_W-3:0], sq_i.rad[RAD_W-1 -: 2]};
      trial = {{(SQ_REM_W-ROOT_W-2){1'b0}}, sq_i.root, 2'b01};
      sq_in.rad = {sq_i.rad[RAD_W-3:0], 2'b00};
      if (work >= trial) begin
         sq_in.rem  = work - trial;
         sq_in.root = {sq_i.root[ROOT_W-2:0], 1'b1};
      end else begin
         sq_in.rem  = work;
         sq_in.root = {sq_i.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sq_ff <= sq_in;
      end
   end

   assign sq_o = sq_ff;

endmodule

FILE: sv/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell
// one restoring division step: one dividend bit in, one quotient bit out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qrs_div_cell import qrs_pkg::*; (
   input  logic   clock,
   input  logic   load,
   input  dv_type dv_i,
   output dv_type dv_o
);

   dv_type              dv_ff;
   dv_type              dv_in;
   logic [DV_REM_W-1:0] work;
   logic [DV_REM_W-1:0] den_ext;

   // shift in the next dividend bit and subtract when it fits
   always_comb begin
      work    = {dv_i.rem[DV_REM_W-2:0], dv_i.dvd[DVD_W-1]};
      den_ext = {1'b0, dv_i.den};
      dv_in.dvd = {dv_i.dvd[DVD_W-2:0], 1'b0};
      dv_in.den = dv_i.den;
      if (work >= den_ext) begin
         dv_in.rem = work - den_ext;
         dv_in.quo = {dv_i.quo[DVD_W-2:0], 1'b1};
      end else begin
         dv_in.rem = work;
         dv_in.quo = {dv_i.quo[DVD_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dv_ff <= dv_in;
      end
   end

   assign dv_o = dv_ff;

endmodule

FILE: sv/quadratic_root_solver_unit.sv
// Quadratic root solver: each beat on req carries signed Q16.16 coefficients
// a, b and c, and one beat on rsp returns the root kind, two Q16.16 values and
// a saturation flag. A new beat is taken every cycle unless the full chain is
// held behind a stalled rsp. A beat passes 33 square root cells (one root
// bit each) followed by 50 divider cells (one quotient bit each), plus the
// multiply, discriminant, numerator and output stages. Every stage holds
// its beat only while the stage after it is full, so a waiting result does
// not stop intake until the chain behind it has filled.
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// pipelined quadratic formula on fixed-point coefficients
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quadratic_root_solver_unit_defines.svh"

module quadratic_root_solver_unit import qrs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,   // coef_a, coef_b, coef_c
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,   // first_value, second_value, saturated
   output logic [KIND_W-1:0] rsp_tuser    // root_kind
);

   localparam int ST_MUL = 0;
   localparam int ST_DSC = 1;
   localparam int ST_SQ0 = 2;
   localparam int ST_NUM = ST_SQ0 + ROOT_W;
   localparam int ST_DV0 = ST_NUM + 1;
   localparam int ST_OUT = ST_DV0 + DVD_W;
   localparam int NSTG   = ST_OUT + 1;

   typedef struct packed {
      logic [WORD_BITS-1:0] val;
      logic                 sat;
   } lane_type;

   // stage occupancy and advance
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG-1:0] en;

   // multiply stage
   logic signed [WORD_BITS-1:0] coef_a, coef_b, coef_c;
   logic [WORD_BITS-1:0]        am, bm, cm;
   logic [PROD_W-1:0]           bsq_ff, prod_ff;
   logic                        acneg_ff, an_ff, zero_a_ff;
   logic [WORD_BITS-1:0]        am_ff;
   logic signed [NB_W-1:0]      nb_ff;

   // discriminant stage
   logic [FAC_W-1:0]  fac;
   logic [DIFF_W-1:0] dsum, dpos, dneg_mag, dmag;
   logic              dneg;
   logic [DISC_W-1:0] disc;
   kind_type          kind1;
   sq_type            sq1_ff;
   side_type          side1_ff;

   // square root chain
   sq_type   sq_o   [ROOT_W];
   side_type side_ff[ROOT_W];

   // numerator stage
   logic signed [NB_W-1:0] root_s, nplus, nminus, num1, num2;
   logic [NUM_W-1:0]       mag1, mag2;
   logic                   neg1, neg2;
   dv_type                 dv1_ff, dv2_ff;
   post_type               postn_ff;

   // divider chain
   dv_type   dva_o  [DVD_W];
   dv_type   dvb_o  [DVD_W];
   post_type post_ff[DVD_W];

   // output stage
   lane_type             lane1, lane2;
   kind_type             kind_ff;
   logic [WORD_BITS-1:0] first_ff, second_ff;
   logic                 sat_ff;

   // clip a quotient magnitude to the word range and apply the sign
   function automatic lane_type clip(input logic neg, input logic [DVD_W-1:0] quo);
      lane_type             r;
      logic [DVD_W-1:0]     half;
      logic [DVD_W-1:0]     lim;
      logic [WORD_BITS-1:0] mag;
      half  = {{(DVD_W-WORD_BITS){1'b0}}, 1'b1, {(WORD_BITS-1){1'b0}}};
      lim   = neg ? half : half - 1'b1;
      r.sat = quo > lim;
      mag   = r.sat ? lim[WORD_BITS-1:0] : quo[WORD_BITS-1:0];
      r.val = neg ? (~mag + 1'b1) : mag;
      return r;
   endfunction

   // advance chain: a stage moves when it is empty or its successor moves
   genvar gi;
   generate
      for (gi = 0; gi < NSTG; gi++) begin : g_en
         if (gi == NSTG - 1) begin : g_last
            assign en[gi] = !vld_ff[gi] || rsp_tready;
         end else begin : g_mid
            assign en[gi] = !vld_ff[gi] || en[gi+1];
         end
         if (gi == 0) begin : g_first
            assign vld_in[gi] = en[gi] ? req_tvalid : vld_ff[gi];
         end else begin : g_rest
            assign vld_in[gi] = en[gi] ? vld_ff[gi-1] : vld_ff[gi];
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = en[ST_MUL];

   // magnitudes and products
   always_comb begin
      coef_a = req_tdata[WORD_BITS-1:0];
      coef_b = req_tdata[2*WORD_BITS-1:WORD_BITS];
      coef_c = req_tdata[3*WORD_BITS-1:2*WORD_BITS];
      am = coef_a[WORD_BITS-1] ? (~coef_a + 1'b1) : coef_a;
      bm = coef_b[WORD_BITS-1] ? (~coef_b + 1'b1) : coef_b;
      cm = coef_c[WORD_BITS-1] ? (~coef_c + 1'b1) : coef_c;
   end

   always_ff @(posedge clock) begin
      if (en[ST_MUL]) begin
         bsq_ff    <= PROD_W'(bm) * PROD_W'(bm);
         prod_ff   <= PROD_W'(am) * PROD_W'(cm);
         acneg_ff  <= coef_a[WORD_BITS-1] ^ coef_c[WORD_BITS-1];
         an_ff     <= coef_a[WORD_BITS-1];
         zero_a_ff <= (am == '0);
         am_ff     <= am;
         nb_ff     <= -{{(NB_W-WORD_BITS){coef_b[WORD_BITS-1]}}, coef_b};
      end
   end

   // discriminant magnitude, sign and root kind
   always_comb begin
      fac      = {prod_ff, 2'b00};
      dsum     = {{(DIFF_W-PROD_W){1'b0}}, bsq_ff} + {1'b0, fac};
      dpos     = {{(DIFF_W-PROD_W){1'b0}}, bsq_ff} - {1'b0, fac};
      dneg_mag = {1'b0, fac} - {{(DIFF_W-PROD_W){1'b0}}, bsq_ff};
      dneg     = 1'b0;
      if (acneg_ff) begin
         dmag = dsum;
      end else if ({{(FAC_W-PROD_W){1'b0}}, bsq_ff} >= fac) begin
         dmag = dpos;
      end else begin
         dmag = dneg_mag;
         dneg = 1'b1;
      end
      disc = dmag[DISC_W-1:0];
      if (zero_a_ff) begin
         kind1 = KIND_NONE;
      end else if (disc == '0) begin
         kind1 = KIND_DOUBLE;
      end else if (dneg) begin
         kind1 = KIND_COMPLEX;
      end else begin
         kind1 = KIND_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_DSC]) begin
         sq1_ff.rad    <= {{(RAD_W-DISC_W){1'b0}}, disc};
         sq1_ff.root   <= '0;
         sq1_ff.rem    <= '0;
         side1_ff.kind <= kind1;
         side1_ff.an   <= an_ff;
         side1_ff.nb   <= nb_ff;
         side1_ff.den  <= {am_ff, 1'b0};
      end
   end

   // square root chain with side data alongside
   generate
      for (gi = 0; gi < ROOT_W; gi++) begin : g_sq
         if (gi == 0) begin : g_head
            qrs_sqrt_cell u_cell (
               .clock (clock),
               .load  (en[ST_SQ0+gi]),
               .sq_i  (sq1_ff),
               .sq_o  (sq_o[gi])
            );
            always_ff @(posedge clock) begin
               if (en[ST_SQ0+gi]) begin
                  side_ff[gi] <= side1_ff;
               end
            end
         end else begin : g_body
            qrs_sqrt_cell u_cell (
               .clock (clock),
               .load  (en[ST_SQ0+gi]),
               .sq_i  (sq_o[gi-1]),
               .sq_o  (sq_o[gi])
            );
            always_ff @(posedge clock) begin
               if (en[ST_SQ0+gi]) begin
                  side_ff[gi] <= side_ff[gi-1];
               end
            end
         end
      end
   endgenerate

   // numerators per root kind
   always_comb begin
      root_s = {{(NB_W-ROOT_W){1'b0}}, sq_o[ROOT_W-1].root};
      nplus  = side_ff[ROOT_W-1].nb + root_s;
      nminus = side_ff[ROOT_W-1].nb - root_s;
      num1   = side_ff[ROOT_W-1].nb;
      num2   = side_ff[ROOT_W-1].nb;
      case (side_ff[ROOT_W-1].kind)
         KIND_TWO: begin
            num1 = nplus;
            num2 = nminus;
         end
         KIND_COMPLEX: begin
            num2 = root_s;
         end
         default: begin
         end
      endcase
      mag1 = num1[NB_W-1] ? NUM_W'(-num1) : num1[NUM_W-1:0];
      mag2 = num2[NB_W-1] ? NUM_W'(-num2) : num2[NUM_W-1:0];
      neg1 = num1[NB_W-1] ^ side_ff[ROOT_W-1].an;
      neg2 = (side_ff[ROOT_W-1].kind == KIND_COMPLEX) ? 1'b0
           : (num2[NB_W-1] ^ side_ff[ROOT_W-1].an);
   end

   always_ff @(posedge clock) begin
      if (en[ST_NUM]) begin
         dv1_ff.dvd    <= {mag1, {FRAC_BITS{1'b0}}};
         dv1_ff.quo    <= '0;
         dv1_ff.rem    <= '0;
         dv1_ff.den    <= side_ff[ROOT_W-1].den;
         dv2_ff.dvd    <= {mag2, {FRAC_BITS{1'b0}}};
         dv2_ff.quo    <= '0;
         dv2_ff.rem    <= '0;
         dv2_ff.den    <= side_ff[ROOT_W-1].den;
         postn_ff.kind <= side_ff[ROOT_W-1].kind;
         postn_ff.neg1 <= neg1;
         postn_ff.neg2 <= neg2;
      end
   end

   // two divider lanes in lockstep
   generate
      for (gi = 0; gi < DVD_W; gi++) begin : g_dv
         if (gi == 0) begin : g_head
            qrs_div_cell u_lane_a (
               .clock (clock),
               .load  (en[ST_DV0+gi]),
               .dv_i  (dv1_ff),
               .dv_o  (dva_o[gi])
            );
            qrs_div_cell u_lane_b (
               .clock (clock),
               .load  (en[ST_DV0+gi]),
               .dv_i  (dv2_ff),
               .dv_o  (dvb_o[gi])
            );
            always_ff @(posedge clock) begin
               if (en[ST_DV0+gi]) begin
                  post_ff[gi] <= postn_ff;
               end
            end
         end else begin : g_body
            qrs_div_cell u_lane_a (
               .clock (clock),
               .load  (en[ST_DV0+gi]),
               .dv_i  (dva_o[gi-1]),
               .dv_o  (dva_o[gi])
            );
            qrs_div_cell u_lane_b (
               .clock (clock),
               .load  (en[ST_DV0+gi]),
               .dv_i  (dvb_o[gi-1]),
               .dv_o  (dvb_o[gi])
            );
            always_ff @(posedge clock) begin
               if (en[ST_DV0+gi]) begin
                  post_ff[gi] <= post_ff[gi-1];
               end
            end
         end
      end
   endgenerate

   // clip, sign and register the result beat
   always_comb begin
      lane1 = clip(post_ff[DVD_W-1].neg1, dva_o[DVD_W-1].quo);
      lane2 = clip(post_ff[DVD_W-1].neg2, dvb_o[DVD_W-1].quo);
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         kind_ff <= post_ff[DVD_W-1].kind;
         if (post_ff[DVD_W-1].kind == KIND_NONE) begin
            first_ff  <= '0;
            second_ff <= '0;
            sat_ff    <= 1'b0;
         end else begin
            first_ff  <= lane1.val;
            second_ff <= lane2.val;
            sat_ff    <= lane1.sat | lane2.sat;
         end
      end
   end

   assign rsp_tvalid = vld_ff[ST_OUT];
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {{(RSP_W-2*WORD_BITS-1){1'b0}}, sat_ff, second_ff, first_ff};

   // checks
   `QRS_ASSERT_IMP(a_none_zero, rsp_tvalid && (rsp_tuser == KIND_NONE),
      rsp_tdata == '0, "zero a must give zero values")
   `QRS_ASSERT_IMP(a_double_same, rsp_tvalid && (rsp_tuser == KIND_DOUBLE),
      first_ff == second_ff, "double root values differ")
   `QRS_ASSERT_IMP(a_imag_pos, rsp_tvalid && (rsp_tuser == KIND_COMPLEX),
      !second_ff[WORD_BITS-1], "imaginary magnitude negative")
   `QRS_ASSERT_IMP(a_stall_full, !req_tready, rsp_tvalid && !rsp_tready,
      "intake stalled without a blocked output")
   `QRS_ASSERT_NXT(a_drain, rsp_tvalid && rsp_tready && !vld_ff[ST_OUT-1],
      !rsp_tvalid, "output beat repeated")

endmodule

FILE: tb/quadratic_root_solver_unit_tb.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit_tb
// drives coefficient beats in random bursts, stalls the result side on its own
// pattern, and compares every result beat with a behavioral root predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quadratic_root_solver_unit_tb;
   import qrs_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] coef_c;
      logic signed [WORD_BITS-1:0] coef_b;
      logic signed [WORD_BITS-1:0] coef_a;
   } coef_type;

   typedef struct {
      kind_type             kind;
      logic [WORD_BITS-1:0] first_value;
      logic [WORD_BITS-1:0] second_value;
      logic                 saturated;
   } roots_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic [KIND_W-1:0] rsp_tuser;

   coef_type  coef_queue[$];
   roots_type roots_queue[$];
   int        error_count;
   int        idle_cycles;
   int        burst_left;
   int        gap_left;
   int        stall_phase;
   bit        stim_done;

   quadratic_root_solver_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // (nmag << FRAC_BITS) / den truncated, signed and clipped to a word
   function automatic logic [WORD_BITS-1:0] scaled_quotient(input bit neg,
         input logic [127:0] nmag, input logic [127:0] den, inout bit sat);
      logic [127:0] quo;
      logic [127:0] limit;
      quo   = (nmag << FRAC_BITS) / den;
      limit = neg ? (128'd1 << (WORD_BITS - 1)) : ((128'd1 << (WORD_BITS - 1)) - 1);
      if (quo > limit) begin
         quo = limit;
         sat = 1'b1;
      end
      return neg ? WORD_BITS'(-quo) : WORD_BITS'(quo);
   endfunction

   // floor square root of a discriminant magnitude
   function automatic logic [127:0] disc_sqrt(input logic [127:0] v);
      logic [127:0] root;
      logic [127:0] cand;
      root = '0;
      for (int i = 63; i >= 0; i--) begin
         cand = root | (128'd1 << i);
         if (cand * cand <= v) root = cand;
      end
      return root;
   endfunction

   // roots of one coefficient set
   function automatic roots_type solve_roots(input coef_type co);
      roots_type    r;
      logic signed [127:0] a, b, c, disc, nb, num, s, den;
      bit           sat;
      a = co.coef_a;
      b = co.coef_b;
      c = co.coef_c;
      sat = 1'b0;
      r.kind = KIND_NONE;
      r.first_value = '0;
      r.second_value = '0;
      r.saturated = 1'b0;
      if (a == 0) return r;
      disc = b * b - 4 * a * c;
      den  = (a < 0) ? -2 * a : 2 * a;
      nb   = -b;
      s    = disc_sqrt(disc < 0 ? -disc : disc);
      if (disc == 0) begin
         r.kind = KIND_DOUBLE;
         r.first_value = scaled_quotient((nb < 0) != (a < 0), nb < 0 ? -nb : nb, den, sat);
         r.second_value = r.first_value;
      end else if (disc > 0) begin
         r.kind = KIND_TWO;
         num = nb + s;
         r.first_value = scaled_quotient((num < 0) != (a < 0), num < 0 ? -num : num, den, sat);
         num = nb - s;
         r.second_value = scaled_quotient((num < 0) != (a < 0), num < 0 ? -num : num, den, sat);
      end else begin
         r.kind = KIND_COMPLEX;
         r.first_value = scaled_quotient((nb < 0) != (a < 0), nb < 0 ? -nb : nb, den, sat);
         r.second_value = scaled_quotient(1'b0, s, den, sat);
      end
      r.saturated = sat;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
         input logic [63:0] want);
      $display("%0t mismatch %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic logic [WORD_BITS-1:0] rand_word(input int mode);
      case (mode)
         0: return $urandom;
         1: return WORD_BITS'($signed($urandom_range(0, 255) - 128)) << FRAC_BITS;
         2: return WORD_BITS'($signed($urandom_range(0, 65535) - 32768)) << 8;
         default: return WORD_BITS'($signed($urandom_range(0, 2047) - 1024));
      endcase
   endfunction

   function automatic coef_type make_coef(input logic [31:0] a, input logic [31:0] b,
         input logic [31:0] c);
      coef_type co;
      co.coef_a = a;
      co.coef_b = b;
      co.coef_c = c;
      return co;
   endfunction

   // stimulus: directed corners then random sets
   initial begin
      logic [31:0] a, b, r1, r2;
      int mode;
      // a zero, extremes of every field
      coef_queue.push_back(make_coef(32'h0, 32'h7fffffff, 32'h80000000));
      coef_queue.push_back(make_coef(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      coef_queue.push_back(make_coef(32'h80000000, 32'h80000000, 32'h80000000));
      coef_queue.push_back(make_coef(32'h80000000, 32'h7fffffff, 32'h7fffffff));
      coef_queue.push_back(make_coef(32'hffffffff, 32'hffffffff, 32'hffffffff));
      coef_queue.push_back(make_coef(32'h1, 32'h80000000, 32'h0));
      coef_queue.push_back(make_coef(32'h1, 32'h7fffffff, 32'h80000000));
      // double root: x^2 - 2x + 1 and b zero, c zero
      coef_queue.push_back(make_coef(32'h10000, 32'hfffe0000, 32'h10000));
      coef_queue.push_back(make_coef(32'h10000, 32'h0, 32'h0));
      coef_queue.push_back(make_coef(32'hffff0000, 32'h40000, 32'hfffc0000));
      // two real roots, complex pair
      coef_queue.push_back(make_coef(32'h10000, 32'h0, 32'hffff0000));
      coef_queue.push_back(make_coef(32'h10000, 32'h0, 32'h10000));
      coef_queue.push_back(make_coef(32'hfffe0000, 32'h30000, 32'h50000));
      coef_queue.push_back(make_coef(32'h10000, 32'h20000, 32'h50000));
      // saturating quotients with tiny a
      coef_queue.push_back(make_coef(32'h1, 32'h10000, 32'h0));
      coef_queue.push_back(make_coef(32'hffffffff, 32'h1000, 32'h7fffffff));
      coef_queue.push_back(make_coef(32'h1, 32'h0, 32'h7fffffff));
      coef_queue.push_back(make_coef(32'h0, 32'h0, 32'h0));
      for (int i = 0; i < 1550; i++) begin
         mode = $urandom_range(0, 9);
         if (mode == 9) begin
            // a zero
            coef_queue.push_back(make_coef(0, $urandom, $urandom));
         end else if (mode == 8) begin
            // perfect square: a (x - r)^2 gives a zero discriminant
            a  = WORD_BITS'($signed($urandom_range(1, 31) - 16));
            if (a == 0) a = 1;
            r1 = WORD_BITS'($signed($urandom_range(0, 2000) - 1000));
            coef_queue.push_back(make_coef(a, -2 * a * r1, a * r1 * r1));
         end else if (mode == 7) begin
            // well scaled integer roots
            a  = WORD_BITS'($signed($urandom_range(1, 63) - 32)) << FRAC_BITS;
            if (a == 0) a = 32'h10000;
            r1 = WORD_BITS'($signed($urandom_range(0, 60) - 30));
            r2 = WORD_BITS'($signed($urandom_range(0, 60) - 30));
            b  = -(a * (r1 + r2));
            coef_queue.push_back(make_coef(a, b, a * r1 * r2 >> 0));
         end else begin
            coef_queue.push_back(make_coef(rand_word(mode % 4), rand_word((mode + 1) % 4),
                                           rand_word((mode + 2) % 4)));
         end
      end
   end

   // reset, then wait for all beats to drain
   initial begin
      reset = 1'b1;
      error_count = 0;
      stim_done = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (coef_queue.size() == 0 && roots_queue.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && roots_queue.size() == 0) begin
         $display("quadratic_root_solver_unit_tb: PASS");
      end else begin
         $display("quadratic_root_solver_unit_tb: FAIL");
      end
      $finish;
   end

   // driver: bursts of beats with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) roots_queue.push_back(solve_roots(coef_type'(req_tdata)));
         if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (coef_queue.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_W'(coef_queue.pop_front());
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result side stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         if (stall_phase[9:8] == 2'd0) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      roots_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("quadratic_root_solver_unit_tb: FAIL");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (roots_queue.size() == 0) begin
               report_mismatch("unexpected beat", rsp_tdata[63:0], 64'd0);
            end else begin
               want = roots_queue.pop_front();
               if (rsp_tuser !== want.kind)
                  report_mismatch("root_kind", 64'(rsp_tuser), 64'(want.kind));
               if (rsp_tdata[WORD_BITS-1:0] !== want.first_value)
                  report_mismatch("first_value", 64'(rsp_tdata[WORD_BITS-1:0]),
                                  64'(want.first_value));
               if (rsp_tdata[2*WORD_BITS-1:WORD_BITS] !== want.second_value)
                  report_mismatch("second_value", 64'(rsp_tdata[2*WORD_BITS-1:WORD_BITS]),
                                  64'(want.second_value));
               if (rsp_tdata[2*WORD_BITS] !== want.saturated)
                  report_mismatch("saturated", 64'(rsp_tdata[2*WORD_BITS]),
                                  64'(want.saturated));
            end
         end
      end
   end

endmodule
